// ===== sv/ucrl_pkg.sv =====
// ----------------------------------------------------------------------------
// ucrl_pkg: shared types and constants of the update coalescing rate limiter
// Table geometry, opcode and outcome codes, entry read and write bundles.
// ----------------------------------------------------------------------------
package ucrl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_BITS      = 32;
  localparam int TIME_BITS     = 48;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int Q_W           = 16;
  localparam int MIN_W         = 32;

  localparam logic [Q_W-1:0] Q_ONE = 16'd32768;

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_QUEUE    = 3'd2;
  localparam logic [2:0] OP_COLLECT  = 3'd3;
  localparam logic [2:0] OP_MARK     = 3'd4;

  localparam logic [2:0] OC_INVALID   = 3'd0;
  localparam logic [2:0] OC_COALESCED = 3'd1;
  localparam logic [2:0] OC_READY     = 3'd2;
  localparam logic [2:0] OC_ACCEPTED  = 3'd3;
  localparam logic [2:0] OC_FULL      = 3'd4;
  localparam logic [2:0] OC_NONE      = 3'd5;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] last;
    logic                 pif;
    logic [Q_W-1:0]       piv;
    logic                 psf;
    logic [Q_W-1:0]       psv;
  } entry_t;

  typedef struct packed {
    logic                 we_key;
    logic                 we_last;
    logic                 we_upd;
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] last;
    logic                 pif;
    logic [Q_W-1:0]       piv;
    logic                 psf;
    logic [Q_W-1:0]       psv;
  } entry_wr_t;

endpackage

// ===== sv/ucrl_if.sv =====
// ----------------------------------------------------------------------------
// ucrl_if: channel interfaces of the update coalescing rate limiter
// Request, result and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------
interface ucrl_req_if import ucrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           opcode;
  logic [KEY_BITS-1:0]  request_id;
  logic [TIME_BITS-1:0] time_ticks;
  logic                 set_intensity;
  logic [Q_W-1:0]       intensity;
  logic                 set_sharpness;
  logic [Q_W-1:0]       sharpness;
  modport source (output valid, opcode, request_id, time_ticks, set_intensity,
                  intensity, set_sharpness, sharpness, input ready);
  modport sink (input valid, opcode, request_id, time_ticks, set_intensity,
                intensity, set_sharpness, sharpness, output ready);
endinterface

interface ucrl_rsp_if import ucrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          outcome;
  logic [KEY_BITS-1:0] result_id;
  logic                out_set_intensity;
  logic [Q_W-1:0]      out_intensity;
  logic                out_set_sharpness;
  logic [Q_W-1:0]      out_sharpness;
  logic                any_pending;
  logic                last_of_run;
  modport source (output valid, outcome, result_id, out_set_intensity, out_intensity,
                  out_set_sharpness, out_sharpness, any_pending, last_of_run,
                  input ready);
  modport sink (input valid, outcome, result_id, out_set_intensity, out_intensity,
                out_set_sharpness, out_sharpness, any_pending, last_of_run,
                output ready);
endinterface

interface ucrl_cfg_if import ucrl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MIN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/update_coalescing_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// update_coalescing_rate_limiter: keyed playback table with update coalescing
// Registers playbacks, merges parameter updates and releases them only once
// min_interval ticks have passed since the playback's register or mark time.
// ----------------------------------------------------------------------------
// Use:
//   req carries one command beat (register, remove, queue, collect, mark
//   attempted). rsp returns result beats; last_of_run flags the final beat
//   of a command. cfg writes min_interval and should only be used while
//   the block is idle.
// Timing:
//   The block handles one command at a time; req.ready is low while busy.
//   A sequencer walks the table one entry per cycle through a single
//   read/write port and one shared readiness compare unit.
//   Register, remove, queue, mark: a key search over every entry, then an
//   act step that loads the result.
//   Collect: a pass marking ready entries, then one minimum key search
//   per emitted beat, or one search and a none beat if nothing is ready.
// Reset:
//   rst (synchronous) empties the table, clears min_interval and drops
//   any held result beat.
// Back-pressure:
//   A finished beat sits in the rsp register; the sequencer holds in its
//   act, emit or none state until that register is free, so nothing is lost.
// ----------------------------------------------------------------------------
module update_coalescing_rate_limiter import ucrl_pkg::*; (
  input  logic clk,
  input  logic rst,
  ucrl_req_if.sink   req,
  ucrl_rsp_if.source rsp,
  ucrl_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_MARK, S_FIND, S_EMIT, S_NONE
  } state_t;

  state_t state;

  // latched command
  logic [2:0]           op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [TIME_BITS-1:0] t_q;
  logic                 si_q;
  logic [Q_W-1:0]       iv_q;
  logic                 ss_q;
  logic [Q_W-1:0]       sv_q;

  logic [MIN_W-1:0]     min_interval;
  logic [IDX_W-1:0]     idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  logic [KEY_BITS-1:0]  best_key;

  logic [TABLE_ENTRIES-1:0] valid_v;
  logic [TABLE_ENTRIES-1:0] pend_v;
  logic [TABLE_ENTRIES-1:0] rdy_v;

  // result register
  logic                 rsp_valid;
  logic [2:0]           rsp_outcome;
  logic [KEY_BITS-1:0]  rsp_id;
  logic                 rsp_sif;
  logic [Q_W-1:0]       rsp_iv;
  logic                 rsp_ssf;
  logic [Q_W-1:0]       rsp_sv;
  logic                 rsp_ap;
  logic                 rsp_last;

  entry_t    rd;
  entry_wr_t wr;
  logic      entry_ready;

  ucrl_table u_table (
    .clk (clk),
    .idx (idx),
    .wr  (wr),
    .rd  (rd)
  );

  ucrl_ready_unit u_ready (
    .now          (t_q),
    .last         (rd.last),
    .min_interval (min_interval),
    .ready        (entry_ready)
  );

  // combinational step results
  logic                     out_free;
  logic                     load_rsp;
  logic                     idx_last;
  logic                     key_hit;
  logic                     cand;
  logic [TABLE_ENTRIES-1:0] idx_bit;
  logic [TABLE_ENTRIES-1:0] valid_after;
  logic [TABLE_ENTRIES-1:0] pend_after;
  logic [2:0]               act_oc;
  logic                     act_emit;
  logic                     m_if;
  logic [Q_W-1:0]           m_iv;
  logic                     m_sf;
  logic [Q_W-1:0]           m_sv;
  logic                     q_ok;
  logic                     collect_ap;

  assign out_free  = !rsp_valid || rsp.ready;
  // a new beat goes into the result register this cycle
  assign load_rsp  = out_free &&
                     ((state == S_ACT) || (state == S_EMIT) || (state == S_NONE));
  assign idx_last  = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign idx_bit   = TABLE_ENTRIES'(1) << idx;
  assign key_hit   = valid_v[idx] && (rd.key == key_q);
  assign cand      = rdy_v[idx] && (!best_found || (rd.key < best_key));
  // entries marked ready all leave during collect, so what stays pending is fixed
  assign collect_ap = |(valid_v & pend_v & ~rdy_v);

  always_comb begin
    wr          = '0;
    valid_after = valid_v;
    pend_after  = pend_v;
    act_oc      = OC_INVALID;
    act_emit    = 1'b0;
    m_if        = si_q ? 1'b1 : rd.pif;
    m_iv        = si_q ? iv_q : rd.piv;
    m_sf        = ss_q ? 1'b1 : rd.psf;
    m_sv        = ss_q ? sv_q : rd.psv;
    q_ok        = hit_found && (si_q || ss_q) && (!si_q || (iv_q <= Q_ONE)) &&
                  (!ss_q || (sv_q <= Q_ONE));
    unique case (state)
      S_ACT: begin
        case (op_q)
          OP_REGISTER: begin
            if (key_q == '0) begin
              act_oc = OC_INVALID;
            end else if (hit_found || free_found) begin
              act_oc              = OC_ACCEPTED;
              wr.we_key           = 1'b1;
              wr.we_last          = 1'b1;
              wr.we_upd           = 1'b1;
              wr.key              = key_q;
              wr.last             = t_q;
              valid_after[idx]    = 1'b1;
              pend_after[idx]     = 1'b0;
            end else begin
              act_oc = OC_FULL;
            end
          end
          OP_REMOVE: begin
            if (hit_found) begin
              act_oc           = OC_ACCEPTED;
              wr.we_upd        = 1'b1;
              valid_after[idx] = 1'b0;
              pend_after[idx]  = 1'b0;
            end
          end
          OP_MARK: begin
            if (hit_found) begin
              act_oc     = OC_ACCEPTED;
              wr.we_last = 1'b1;
              wr.last    = t_q;
            end
          end
          OP_QUEUE: begin
            if (q_ok) begin
              wr.we_upd = 1'b1;
              if (entry_ready) begin
                // emit merged update at once and leave the entry clean
                act_oc          = OC_READY;
                act_emit        = 1'b1;
                pend_after[idx] = 1'b0;
              end else begin
                act_oc          = OC_COALESCED;
                pend_after[idx] = 1'b1;
                wr.pif          = m_if;
                wr.piv          = m_iv;
                wr.psf          = m_sf;
                wr.psv          = m_sv;
              end
            end
          end
          default: act_oc = OC_INVALID;
        endcase
        if (!out_free) begin
          wr          = '0;
          valid_after = valid_v;
          pend_after  = pend_v;
        end
      end
      S_EMIT: begin
        // clear the emitted entry's pending update
        wr.we_upd = out_free;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid_v      <= '0;
      rsp_valid    <= 1'b0;
      min_interval <= '0;
      idx          <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        min_interval <= cfg.data;
      end
      if (rsp_valid && rsp.ready && !load_rsp) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q       <= req.opcode;
            key_q      <= req.request_id;
            t_q        <= req.time_ticks;
            si_q       <= req.set_intensity;
            iv_q       <= req.intensity;
            ss_q       <= req.set_sharpness;
            sv_q       <= req.sharpness;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= (req.opcode == OP_COLLECT) ? S_MARK : S_SCAN;
          end
        end
        S_SCAN: begin
          if (key_hit && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          if (!valid_v[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx_last) begin
            // point at the hit, else the lowest free slot
            if (key_hit && !hit_found) begin
              idx <= idx;
            end else if (hit_found) begin
              idx <= hit_idx;
            end else if (free_found) begin
              idx <= free_idx;
            end
            state <= S_ACT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ACT: begin
          if (out_free) begin
            valid_v     <= valid_after;
            pend_v      <= pend_after;
            rsp_valid   <= 1'b1;
            rsp_outcome <= act_oc;
            rsp_id      <= key_q;
            rsp_sif     <= act_emit && m_if;
            rsp_iv      <= (act_emit && m_if) ? m_iv : '0;
            rsp_ssf     <= act_emit && m_sf;
            rsp_sv      <= (act_emit && m_sf) ? m_sv : '0;
            rsp_ap      <= |(valid_after & pend_after);
            rsp_last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_MARK: begin
          rdy_v[idx] <= valid_v[idx] && pend_v[idx] && entry_ready;
          if (idx_last) begin
            idx        <= '0;
            best_found <= 1'b0;
            state      <= S_FIND;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIND: begin
          if (cand) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best_key   <= rd.key;
          end
          if (idx_last) begin
            if (cand) begin
              idx   <= idx;
              state <= S_EMIT;
            end else if (best_found) begin
              idx   <= best_idx;
              state <= S_EMIT;
            end else begin
              state <= S_NONE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            pend_v[idx] <= 1'b0;
            rdy_v[idx]  <= 1'b0;
            rsp_valid   <= 1'b1;
            rsp_outcome <= OC_READY;
            rsp_id      <= rd.key;
            rsp_sif     <= rd.pif;
            rsp_iv      <= rd.pif ? rd.piv : '0;
            rsp_ssf     <= rd.psf;
            rsp_sv      <= rd.psf ? rd.psv : '0;
            rsp_ap      <= collect_ap;
            rsp_last    <= ((rdy_v & ~idx_bit) == '0);
            best_found  <= 1'b0;
            state       <= ((rdy_v & ~idx_bit) == '0) ? S_IDLE : S_FIND;
            idx         <= '0;
          end
        end
        S_NONE: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            rsp_outcome <= OC_NONE;
            rsp_id      <= '0;
            rsp_sif     <= 1'b0;
            rsp_iv      <= '0;
            rsp_ssf     <= 1'b0;
            rsp_sv      <= '0;
            rsp_ap      <= collect_ap;
            rsp_last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.outcome           = rsp_outcome;
  assign rsp.result_id         = rsp_id;
  assign rsp.out_set_intensity = rsp_sif;
  assign rsp.out_intensity     = rsp_iv;
  assign rsp.out_set_sharpness = rsp_ssf;
  assign rsp.out_sharpness     = rsp_sv;
  assign rsp.any_pending       = rsp_ap;
  assign rsp.last_of_run       = rsp_last;

endmodule

// ===== sv/ucrl_ready_unit.sv =====
// ----------------------------------------------------------------------------
// ucrl_ready_unit: shared readiness compare
// Ready when now >= last and now - last >= min_interval.
// ----------------------------------------------------------------------------
module ucrl_ready_unit import ucrl_pkg::*; (
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] last,
  input  logic [MIN_W-1:0]     min_interval,
  output logic                 ready
);
  logic [TIME_BITS:0] diff;

  always_comb begin
    diff  = {1'b0, now} - {1'b0, last};
    // borrow set means time went backwards: never ready
    ready = !diff[TIME_BITS] &&
            (diff[TIME_BITS-1:0] >= TIME_BITS'({{TIME_BITS{1'b0}}, min_interval}));
  end
endmodule

// ===== sv/ucrl_table.sv =====
// ----------------------------------------------------------------------------
// ucrl_table: playback entry store
// One address, shared by read and write and driven by the sequencer index.
// ----------------------------------------------------------------------------
module ucrl_table import ucrl_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  entry_wr_t        wr,
  output entry_t           rd
);
  logic [KEY_BITS-1:0]  key_mem  [TABLE_ENTRIES];
  logic [TIME_BITS-1:0] last_mem [TABLE_ENTRIES];
  logic                 pif_mem  [TABLE_ENTRIES];
  logic [Q_W-1:0]       piv_mem  [TABLE_ENTRIES];
  logic                 psf_mem  [TABLE_ENTRIES];
  logic [Q_W-1:0]       psv_mem  [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we_key) begin
      key_mem[idx] <= wr.key;
    end
    if (wr.we_last) begin
      last_mem[idx] <= wr.last;
    end
    if (wr.we_upd) begin
      pif_mem[idx] <= wr.pif;
      piv_mem[idx] <= wr.piv;
      psf_mem[idx] <= wr.psf;
      psv_mem[idx] <= wr.psv;
    end
  end

  always_comb begin
    rd.key  = key_mem[idx];
    rd.last = last_mem[idx];
    rd.pif  = pif_mem[idx];
    rd.piv  = piv_mem[idx];
    rd.psf  = psf_mem[idx];
    rd.psv  = psv_mem[idx];
  end
endmodule

// ===== sv/ucrl_checker.sv =====
// ----------------------------------------------------------------------------
// ucrl_checker: port-level checks of the update coalescing rate limiter
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module ucrl_checker import ucrl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [2:0]          outcome,
  input logic [KEY_BITS-1:0] result_id,
  input logic                out_set_intensity,
  input logic [Q_W-1:0]      out_intensity,
  input logic                last_of_run
);

  // busy after taking a command
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while still busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome) && $stable(result_id))
    else $error("stalled result beat changed");

  // only ready beats of a collect may be followed by more beats
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (outcome != OC_READY) |-> last_of_run)
    else $error("non-ready beat not last of run");

  a_none: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (outcome == OC_NONE) |-> (result_id == '0))
    else $error("none-ready beat carries an id");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (outcome != OC_READY) |-> !out_set_intensity && (out_intensity == '0))
    else $error("update fields set on a non-ready beat");

endmodule

bind update_coalescing_rate_limiter ucrl_checker u_ucrl_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .outcome           (rsp.outcome),
  .result_id         (rsp.result_id),
  .out_set_intensity (rsp.out_set_intensity),
  .out_intensity     (rsp.out_intensity),
  .last_of_run       (rsp.last_of_run)
);

// ===== bench/tb_ucrl_if_note.sv =====
// ----------------------------------------------------------------------------
// tb_ucrl_stim_pkg: stimulus row type for the rate limiter bench
// One command beat plus an optional typed-in outcome for directed rows.
// ----------------------------------------------------------------------------
package tb_ucrl_stim_pkg;
  import ucrl_pkg::*;

  typedef struct {
    logic [2:0]           op;
    logic [KEY_BITS-1:0]  id;
    logic [TIME_BITS-1:0] t;
    logic                 si;
    logic [Q_W-1:0]       iv;
    logic                 ss;
    logic [Q_W-1:0]       sv;
    logic                 chk;   // typed-in outcome present
    logic [2:0]           oc;
  } cmd_row_t;

endpackage

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for update_coalescing_rate_limiter
// Walks a directed command table, then random register/remove/mark/queue/
// collect traffic over a small key pool, with random gaps on the command and
// result channels. Every result beat is checked against an in-bench table model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ucrl_pkg::*;
  import tb_ucrl_stim_pkg::*;

  typedef struct packed {
    logic [2:0]          oc;
    logic [KEY_BITS-1:0] id;
    logic                si;
    logic [Q_W-1:0]      iv;
    logic                ss;
    logic [Q_W-1:0]      sv;
    logic                ap;
    logic                lr;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ucrl_req_if req ();
  ucrl_rsp_if rsp ();
  ucrl_cfg_if cfg ();

  update_coalescing_rate_limiter dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                                      .cfg(cfg));

  // Shadow table
  logic [MIN_W-1:0]     gap_ticks;
  logic                 t_valid [TABLE_ENTRIES];
  logic [KEY_BITS-1:0]  t_key   [TABLE_ENTRIES];
  logic [TIME_BITS-1:0] t_last  [TABLE_ENTRIES];
  logic                 t_pend  [TABLE_ENTRIES];
  logic                 t_pif   [TABLE_ENTRIES];
  logic [Q_W-1:0]       t_piv   [TABLE_ENTRIES];
  logic                 t_psf   [TABLE_ENTRIES];
  logic [Q_W-1:0]       t_psv   [TABLE_ENTRIES];

  beat_t due_beats[$];
  int    n_bad = 0;
  int    cycles = 0;
  logic  rsp_go = 1'b1;

  function automatic void wipe(int i);
    t_pend[i] = 0; t_pif[i] = 0; t_piv[i] = 0; t_psf[i] = 0; t_psv[i] = 0;
  endfunction

  function automatic logic due(int i, logic [TIME_BITS-1:0] now);
    return now >= t_last[i] && (now - t_last[i]) >= {16'd0, gap_ticks};
  endfunction

  function automatic beat_t pack_beat(logic [2:0] oc, logic [KEY_BITS-1:0] id, int s);
    beat_t b;
    b = '0;
    b.oc = oc;
    b.id = id;
    if (s >= 0) begin
      b.si = t_pif[s]; b.iv = t_pif[s] ? t_piv[s] : '0;
      b.ss = t_psf[s]; b.sv = t_psf[s] ? t_psv[s] : '0;
    end
    return b;
  endfunction

  // Advance the shadow table by one command and push its result beats
  function automatic void coalesce_predict(cmd_row_t c);
    beat_t run[$];
    int    k, best, emit;
    logic  ok, ap;
    logic [2:0] oc;
    run = {};
    if (c.op == OP_COLLECT) begin
      forever begin
        best = -1;
        if (run.size() >= 16) break;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (t_valid[i] && t_pend[i] && due(i, c.t) &&
              (best < 0 || t_key[i] < t_key[best])) best = i;
        if (best < 0) break;
        run.push_back(pack_beat(OC_READY, t_key[best], best));
        wipe(best);
      end
      if (run.size() == 0) run.push_back(pack_beat(OC_NONE, '0, -1));
    end else begin
      oc = OC_INVALID;
      emit = -1;
      k = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (k < 0 && t_valid[i] && t_key[i] == c.id) k = i;
      case (c.op)
        OP_REGISTER: if (c.id != 0) begin
          if (k < 0)
            for (int i = 0; i < TABLE_ENTRIES; i++) if (k < 0 && !t_valid[i]) k = i;
          if (k < 0) oc = OC_FULL;
          else begin
            t_valid[k] = 1; t_key[k] = c.id; t_last[k] = c.t; wipe(k);
            oc = OC_ACCEPTED;
          end
        end
        OP_REMOVE: if (k >= 0) begin
          t_valid[k] = 0; wipe(k); oc = OC_ACCEPTED;
        end
        OP_MARK: if (k >= 0) begin
          t_last[k] = c.t; oc = OC_ACCEPTED;
        end
        OP_QUEUE: begin
          ok = k >= 0 && (c.si || c.ss) && (!c.si || c.iv <= Q_ONE) &&
               (!c.ss || c.sv <= Q_ONE);
          if (ok) begin
            t_pend[k] = 1;
            if (c.si) begin t_pif[k] = 1; t_piv[k] = c.iv; end
            if (c.ss) begin t_psf[k] = 1; t_psv[k] = c.sv; end
            if (due(k, c.t)) begin oc = OC_READY; emit = k; end
            else oc = OC_COALESCED;
          end
        end
        default: ;
      endcase
      run.push_back(pack_beat(oc, c.id, emit));
      if (emit >= 0) wipe(emit);
    end
    ap = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) if (t_valid[i] && t_pend[i]) ap = 1;
    foreach (run[j]) begin
      run[j].ap = ap;
      run[j].lr = (j == run.size() - 1);
      due_beats.push_back(run[j]);
    end
  endfunction

  // Result side: random stalls, check each beat against the oldest expectation
  beat_t got, want;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.outcome, rsp.result_id, rsp.out_set_intensity, rsp.out_intensity,
              rsp.out_set_sharpness, rsp.out_sharpness, rsp.any_pending,
              rsp.last_of_run};
      if (due_beats.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = due_beats.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int w;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      w = $urandom_range(0, 99);
      // mostly ready, with some short stalls and a few long ones
      if (w < 60) rsp.ready = 1'b1;
      else if (w < 95) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        rsp.ready = 1'b1;
      end else begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        rsp.ready = 1'b1;
      end
    end
  end

  // Command side
  task automatic send_cmd(cmd_row_t c);
    int g;
    g = $urandom_range(0, 9);
    if (g >= 9) repeat ($urandom_range(10, 30)) @(negedge clk);
    else if (g >= 6) repeat ($urandom_range(1, 3)) @(negedge clk);
    req.opcode = c.op; req.request_id = c.id; req.time_ticks = c.t;
    req.set_intensity = c.si; req.intensity = c.iv;
    req.set_sharpness = c.ss; req.sharpness = c.sv;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    if (c.chk && c.op != OP_COLLECT) begin
      coalesce_predict(c);
      if (due_beats[$].oc !== c.oc) begin
        n_bad++;
        if (n_bad <= 10) $display("directed row: outcome %0d, table says %0d",
                                  due_beats[$].oc, c.oc);
      end
    end else coalesce_predict(c);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (due_beats.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_gap(logic [MIN_W-1:0] v);
    cfg.data = v;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    gap_ticks = v;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic cmd_row_t mk(logic [2:0] op, logic [KEY_BITS-1:0] id,
                                  logic [TIME_BITS-1:0] t, logic si, logic [Q_W-1:0] iv,
                                  logic ss, logic [Q_W-1:0] sv, logic chk, logic [2:0] oc);
    cmd_row_t r;
    r = '{op, id, t, si, iv, ss, sv, chk, oc};
    return r;
  endfunction

  cmd_row_t plan[$];
  logic [KEY_BITS-1:0] pool[6];
  logic [TIME_BITS-1:0] now_t;
  int sel;

  initial begin
    cmd_row_t c;
    gap_ticks = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      t_valid[i] = 0; t_key[i] = 0; t_last[i] = 0; wipe(i);
    end
    req.valid = 0; req.opcode = OP_REGISTER; req.request_id = '0; req.time_ticks = '0;
    req.set_intensity = 0; req.intensity = '0; req.set_sharpness = 0; req.sharpness = '0;
    cfg.valid = 0; cfg.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero id, absent keys, validation limits, coalescing, collect
    plan = {
      mk(OP_COLLECT,  0, 0, 0, 0, 0, 0, 1, OC_NONE),
      mk(OP_REGISTER, 0, 5, 0, 0, 0, 0, 1, OC_INVALID),
      mk(OP_REMOVE,   7, 0, 0, 0, 0, 0, 1, OC_INVALID),
      mk(OP_MARK,     7, 0, 0, 0, 0, 0, 1, OC_INVALID),
      mk(OP_REGISTER, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 1, OC_ACCEPTED),
      mk(OP_REGISTER, 1, 0, 0, 0, 0, 0, 1, OC_ACCEPTED),
      mk(OP_QUEUE,    1, 0, 0, 0, 0, 0, 1, OC_INVALID),
      mk(OP_QUEUE,    1, 0, 1, 16'd32769, 0, 0, 1, OC_INVALID),
      mk(OP_QUEUE,    1, 0, 0, 0, 1, 16'hFFFF, 1, OC_INVALID),
      mk(OP_QUEUE,    9, 0, 1, 0, 0, 0, 1, OC_INVALID),
      mk(OP_QUEUE,    1, 0, 1, 16'd32768, 1, 16'd32768, 1, OC_READY),
      mk(OP_QUEUE,    1, 0, 0, 16'hFFFF, 1, 0, 1, OC_READY),
      mk(3'd7,        1, 0, 1, 16'hFFFF, 1, 16'hFFFF, 1, OC_INVALID),
      mk(OP_MARK,     1, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 1, OC_ACCEPTED),
      mk(OP_QUEUE,    1, 0, 1, 100, 0, 0, 1, OC_COALESCED),
      mk(OP_QUEUE,    1, 0, 0, 0, 1, 200, 1, OC_COALESCED),
      mk(OP_COLLECT,  0, 48'hFFFF_FFFF_FFFE, 0, 0, 0, 0, 0, 0),
      mk(OP_COLLECT,  0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0),
      mk(OP_REMOVE,   1, 0, 0, 0, 0, 0, 1, OC_ACCEPTED),
      mk(OP_REMOVE,   32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1, OC_ACCEPTED)
    };
    foreach (plan[i]) send_cmd(plan[i]);
    // fill the table, then one more key is refused
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_cmd(mk(OP_REGISTER, 100 + i, 0, 0, 0, 0, 0, 1, OC_ACCEPTED));
    send_cmd(mk(OP_REGISTER, 500, 0, 0, 0, 0, 0, 1, OC_FULL));
    drain();

    // gap of ten ticks: every entry queued, then one big collect of all sixteen
    write_gap(32'd10);
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
      send_cmd(mk(OP_QUEUE, 100 + i, 3, 1, i, 1, 16'd32768 - i, 1, OC_COALESCED));
    send_cmd(mk(OP_COLLECT, 0, 10, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_cmd(mk(OP_REMOVE, 100 + i, 0, 0, 0, 0, 0, 1, OC_ACCEPTED));
    drain();

    // Random phases over several interval settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_gap(32'hFFFF_FFFF);
        1: write_gap($urandom_range(1, 50));
        2: write_gap(32'd0);
        default: write_gap($urandom_range(0, 1000));
      endcase
      foreach (pool[j]) pool[j] = (j == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 40) + 16*j;
      now_t = (ph == 0) ? 48'hFFFE_0000_0000 : $urandom_range(0, 1000);
      for (int n = 0; n < 10; n++) begin
        now_t += $urandom_range(0, 60);
        sel = $urandom_range(0, 99);
        c = mk(OP_QUEUE, pool[$urandom_range(0, 5)], now_t, $urandom_range(0, 1),
               $urandom_range(0, 32768), $urandom_range(0, 1), $urandom_range(0, 32768),
               0, 0);
        if (sel < 15) c.op = OP_REGISTER;
        else if (sel < 22) c.op = OP_MARK;
        else if (sel < 27) c.op = OP_REMOVE;
        else if (sel < 45) c.op = OP_COLLECT;
        else if (sel < 50) begin
          // noise: odd ids, out-of-range values, stray times
          c.id = $urandom();
          c.iv = Q_W'($urandom_range(0, 65535));
          c.sv = Q_W'($urandom_range(0, 65535));
          c.t = TIME_BITS'({$urandom(), $urandom()});
          c.op = 3'($urandom_range(0, 7));
        end
        send_cmd(c);
        if (n == 5 && ph == 1) drain();
      end
      drain();
    end

    if (n_bad == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
